### rtl/dfps_pkg.sv
// shared types and constants for the dataflash page access sequencer
// no dependencies; used by every module of the block
package dfps_pkg;

  localparam int ADDR_W = 24;
  localparam int LEN_W  = 25;
  localparam int PAGE_W = 11;
  localparam int PNUM_W = 16;
  localparam int POLL_W = 6;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  transfer_length;
    logic [7:0]        status_byte;
  } dfps_in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        command_code;
    logic [ADDR_W-1:0] flash_address;
    logic [PAGE_W-1:0] payload_bytes;
    logic              payload_is_read;
    logic [LEN_W-1:0]  bytes_done;
    logic [1:0]        result_code;
    logic              write_protect_high;
  } dfps_out_t;

  // input opcodes
  localparam logic [1:0] OP_READ     = 2'd0;
  localparam logic [1:0] OP_WRITE    = 2'd1;
  localparam logic [1:0] OP_STATUS   = 2'd2;
  localparam logic [1:0] OP_FINISHED = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_POLL  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // result codes
  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_RANGE     = 2'd1;
  localparam logic [1:0] RES_NOT_READY = 2'd2;
  localparam logic [1:0] RES_MISMATCH  = 2'd3;

  // flash command bytes
  localparam logic [7:0] CMD_READ_CONT = 8'hE8;
  localparam logic [7:0] CMD_XFER_BUF1 = 8'h53;
  localparam logic [7:0] CMD_PROG_BUF1 = 8'h82;
  localparam logic [7:0] CMD_CMP_BUF1  = 8'h60;
  localparam logic [7:0] CMD_STATUS    = 8'hD7;
  localparam logic [7:0] CMD_NONE      = 8'h00;

  // request phases
  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_RD_READY     = 4'd1;
  localparam logic [3:0] PH_RD_FRAME     = 4'd2;
  localparam logic [3:0] PH_WR_XFER      = 4'd3;
  localparam logic [3:0] PH_WR_XFER_POLL = 4'd4;
  localparam logic [3:0] PH_WR_PROG      = 4'd5;
  localparam logic [3:0] PH_WR_PROG_POLL = 4'd6;
  localparam logic [3:0] PH_WR_CMP       = 4'd7;
  localparam logic [3:0] PH_WR_CMP_POLL  = 4'd8;
  localparam logic [3:0] PH_WR_CHECK     = 4'd9;

  // configuration register indexes
  localparam logic [1:0] CFG_BYTES_PER_PAGE = 2'd0;
  localparam logic [1:0] CFG_PAGE_SHIFT     = 2'd1;
  localparam logic [1:0] CFG_DEVICE_BYTES   = 2'd2;
  localparam logic [1:0] CFG_WP_PRESENT     = 2'd3;

  localparam logic [PAGE_W-1:0] RST_BYTES_PER_PAGE = 11'd256;
  localparam logic [3:0]        RST_PAGE_SHIFT     = 4'd9;
  localparam logic [LEN_W-1:0]  RST_DEVICE_BYTES   = 25'd524288;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       set_write;
    logic       div_start;
    logic       start_req;
    logic       adv_sum;
    logic       adv_chunk;
    logic       poll_fresh;
    logic       poll_inc;
    logic       emit;
    logic [1:0] emit_kind;
    logic [1:0] emit_res;
    logic       emit_zero;
    logic [3:0] phase;
  } dfps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       len_zero;
    logic       out_of_range;
    logic       st_ready;
    logic       st_mismatch;
    logic       is_write;
    logic       chunk_full;
    logic       poll_under;
    logic       div_done;
    logic       all_done;
    logic       out_free;
  } dfps_stat_t;

endpackage

### rtl/dfps_div.sv
// restoring divider, one quotient bit per cycle, splits a byte address into page and offset
// depends on dfps_pkg
module dfps_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dfps_pkg::ADDR_W-1:0] dividend,
  input  logic [dfps_pkg::PAGE_W-1:0] divisor,
  output logic [dfps_pkg::ADDR_W-1:0] quotient,
  output logic [dfps_pkg::PAGE_W-1:0] remainder,
  output logic                      done
);
  import dfps_pkg::*;

  localparam int CNT_W = $clog2(ADDR_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ADDR_W - 1);

  logic [ADDR_W-1:0] quo_r, quo_nxt;
  logic [PAGE_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PAGE_W:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[ADDR_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = PAGE_W'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[ADDR_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[PAGE_W-1:0];
        quo_nxt = {quo_r[ADDR_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

### rtl/dfps_dp.sv
// datapath: configuration registers, request state, address divider and result register
// depends on dfps_pkg and dfps_div
module dfps_dp #(
  parameter int RETRY_LIMIT    = 50,
  parameter int MAX_PAGE_BYTES = 1024,
  parameter int ADDRESS_BITS   = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dfps_pkg::dfps_in_t   in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [dfps_pkg::LEN_W-1:0] cfg_wdata,
  input  dfps_pkg::dfps_cmd_t  cmd,
  output dfps_pkg::dfps_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dfps_pkg::dfps_out_t  out_data
);
  import dfps_pkg::*;

  localparam logic [11:0] MAXP      = 12'(MAX_PAGE_BYTES);
  localparam logic [31:0] AMASK     = (32'h1 << ADDRESS_BITS) - 32'h1;
  localparam logic [POLL_W-1:0] RLIM = POLL_W'(RETRY_LIMIT);

  // configuration
  logic [PAGE_W-1:0] bpp_r;
  logic [3:0]        shift_r;
  logic [LEN_W-1:0]  dev_r;
  logic              wp_r;

  // latched item
  logic [1:0]        op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;
  logic [7:0]        st_r;

  // request state
  logic              is_write_r;
  logic [PNUM_W-1:0] page_r;
  logic [PAGE_W-1:0] offset_r;
  logic [LEN_W-1:0]  total_r;
  logic [LEN_W-1:0]  bf_r;
  logic [PAGE_W-1:0] chunk_r;
  logic [POLL_W-1:0] poll_r;

  logic              out_valid_r, out_valid_nxt;
  dfps_out_t         out_r, out_nxt;

  logic [PAGE_W-1:0] eff_page;
  logic [ADDR_W-1:0] div_quo;
  logic [PAGE_W-1:0] div_rem;
  logic              div_done;
  logic [PAGE_W-1:0] room;
  logic [LEN_W-1:0]  rem_len;
  logic [LEN_W:0]    end_addr;
  logic [30:0]       page_sh;
  logic [30:0]       addr_full;
  logic              with_off;

  always_comb begin
    if (bpp_r == '0) begin
      eff_page = PAGE_W'(1);
    end else if ({1'b0, bpp_r} > MAXP) begin
      eff_page = MAXP[PAGE_W-1:0];
    end else begin
      eff_page = bpp_r;
    end
  end

  dfps_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (addr_r),
    .divisor   (eff_page),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  assign room     = eff_page - div_rem;
  assign rem_len  = total_r - bf_r;
  assign end_addr = (LEN_W+1)'(addr_r) + (LEN_W+1)'(len_r);

  always_comb begin
    stat.op           = op_r;
    stat.len_zero     = (len_r == '0);
    stat.out_of_range = (end_addr > (LEN_W+1)'(dev_r));
    stat.st_ready     = st_r[7];
    stat.st_mismatch  = st_r[6];
    stat.is_write     = is_write_r;
    stat.chunk_full   = (chunk_r == eff_page);
    stat.poll_under   = (poll_r < RLIM);
    stat.div_done     = div_done;
    stat.all_done     = (bf_r >= total_r);
    stat.out_free     = !out_valid_r || !out_stall;
  end

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r   <= RST_BYTES_PER_PAGE;
      shift_r <= RST_PAGE_SHIFT;
      dev_r   <= RST_DEVICE_BYTES;
      wp_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BYTES_PER_PAGE: bpp_r   <= cfg_wdata[PAGE_W-1:0];
        CFG_PAGE_SHIFT:     shift_r <= cfg_wdata[3:0];
        CFG_DEVICE_BYTES:   dev_r   <= cfg_wdata;
        CFG_WP_PRESENT:     wp_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_data.opcode;
      addr_r <= in_data.start_address;
      len_r  <= in_data.transfer_length;
      st_r   <= in_data.status_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_write_r <= 1'b0;
      page_r     <= '0;
      offset_r   <= '0;
      total_r    <= '0;
      bf_r       <= '0;
      chunk_r    <= '0;
      poll_r     <= '0;
    end else begin
      if (cmd.set_write) begin
        is_write_r <= op_r[0];
      end
      if (cmd.start_req) begin
        total_r  <= len_r;
        bf_r     <= '0;
        page_r   <= div_quo[PNUM_W-1:0];
        offset_r <= div_rem;
        chunk_r  <= (len_r > LEN_W'(room)) ? room : len_r[PAGE_W-1:0];
      end
      if (cmd.adv_sum) begin
        bf_r     <= bf_r + LEN_W'(chunk_r);
        page_r   <= page_r + 1'b1;
        offset_r <= '0;
      end
      if (cmd.adv_chunk) begin
        chunk_r <= (rem_len > LEN_W'(eff_page)) ? eff_page : rem_len[PAGE_W-1:0];
      end
      if (cmd.poll_fresh) begin
        poll_r <= POLL_W'(1);
      end else if (cmd.poll_inc) begin
        poll_r <= poll_r + 1'b1;
      end
    end
  end

  // device address of the current page, with or without the offset
  assign with_off  = (cmd.phase == PH_RD_FRAME) || (cmd.phase == PH_WR_PROG);
  assign page_sh   = {15'd0, page_r} << shift_r;
  assign addr_full = page_sh + (with_off ? 31'(offset_r) : 31'd0);

  always_comb begin
    out_nxt     = '0;
    out_nxt.kind = cmd.emit_kind;
    case (cmd.emit_kind)
      KIND_FRAME: begin
        out_nxt.flash_address = addr_full[ADDR_W-1:0] & AMASK[ADDR_W-1:0];
        case (cmd.phase)
          PH_RD_FRAME: begin
            out_nxt.command_code    = CMD_READ_CONT;
            out_nxt.payload_bytes   = chunk_r;
            out_nxt.payload_is_read = 1'b1;
          end
          PH_WR_XFER: begin
            out_nxt.command_code = CMD_XFER_BUF1;
          end
          PH_WR_PROG: begin
            out_nxt.command_code  = CMD_PROG_BUF1;
            out_nxt.payload_bytes = chunk_r;
          end
          default: begin
            out_nxt.command_code = CMD_CMP_BUF1;
          end
        endcase
      end
      KIND_POLL: begin
        out_nxt.command_code    = CMD_STATUS;
        out_nxt.payload_bytes   = PAGE_W'(1);
        out_nxt.payload_is_read = 1'b1;
      end
      default: begin
        out_nxt.command_code = CMD_NONE;
        out_nxt.bytes_done   = cmd.emit_zero ? '0 : bf_r;
        out_nxt.result_code  = cmd.emit_res;
      end
    endcase
    out_nxt.write_protect_high = (cmd.emit_kind != KIND_DONE) && is_write_r && wp_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a result never overwrites a beat that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending beat");

  a_poll_limit: assert property (@(posedge clk) disable iff (!rst_n)
    poll_r <= RLIM)
    else $error("poll count past retry limit");

endmodule

### rtl/dfps_ctrl.sv
// controller: request phase and per-item sequencing, drives the datapath by command struct
// depends on dfps_pkg
module dfps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dfps_pkg::dfps_stat_t stat,
  output dfps_pkg::dfps_cmd_t  cmd
);
  import dfps_pkg::*;

  localparam logic [2:0] SQ_IDLE  = 3'd0;
  localparam logic [2:0] SQ_EXEC  = 3'd1;
  localparam logic [2:0] SQ_DIV   = 3'd2;
  localparam logic [2:0] SQ_START = 3'd3;
  localparam logic [2:0] SQ_ADV1  = 3'd4;
  localparam logic [2:0] SQ_ADV2  = 3'd5;
  localparam logic [2:0] SQ_ADV3  = 3'd6;
  localparam logic [2:0] SQ_EMIT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [3:0] phase_r, phase_nxt;
  logic [1:0] ek_r, ek_nxt;
  logic [1:0] rc_r, rc_nxt;
  logic       dz_r, dz_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    ek_nxt    = ek_r;
    rc_nxt    = rc_r;
    dz_nxt    = dz_r;
    cmd           = '0;
    cmd.phase     = phase_r;
    cmd.emit_kind = ek_r;
    cmd.emit_res  = rc_r;
    cmd.emit_zero = dz_r;

    case (state_r)
      SQ_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = SQ_EXEC;
        end
      end

      SQ_EXEC: begin
        state_nxt = SQ_IDLE;
        if (phase_r == PH_IDLE) begin
          if (stat.op == OP_READ || stat.op == OP_WRITE) begin
            cmd.set_write = 1'b1;
            if (stat.len_zero) begin
              {ek_nxt, rc_nxt, dz_nxt} = {KIND_DONE, RES_OK, 1'b1};
              state_nxt = SQ_EMIT;
            end else if (stat.out_of_range) begin
              {ek_nxt, rc_nxt, dz_nxt} = {KIND_DONE, RES_RANGE, 1'b1};
              state_nxt = SQ_EMIT;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = SQ_DIV;
            end
          end
        end else if (stat.op == OP_FINISHED) begin
          case (phase_r)
            PH_RD_FRAME: state_nxt = SQ_ADV1;
            PH_WR_XFER, PH_WR_PROG, PH_WR_CMP: begin
              cmd.poll_fresh = 1'b1;
              phase_nxt      = phase_r + 4'd1;
              ek_nxt         = KIND_POLL;
              state_nxt      = SQ_EMIT;
            end
            default: begin
            end
          endcase
        end else if (stat.op == OP_STATUS) begin
          if (phase_r == PH_WR_CHECK) begin
            if (stat.st_mismatch) begin
              {ek_nxt, rc_nxt, dz_nxt} = {KIND_DONE, RES_MISMATCH, 1'b0};
              phase_nxt = PH_IDLE;
              state_nxt = SQ_EMIT;
            end else begin
              state_nxt = SQ_ADV1;
            end
          end else if (phase_r == PH_RD_READY || phase_r == PH_WR_XFER_POLL ||
                       phase_r == PH_WR_PROG_POLL || phase_r == PH_WR_CMP_POLL) begin
            state_nxt = SQ_EMIT;
            if (!stat.st_ready) begin
              if (stat.poll_under) begin
                cmd.poll_inc = 1'b1;
                ek_nxt       = KIND_POLL;
              end else begin
                {ek_nxt, rc_nxt, dz_nxt} = {KIND_DONE, RES_NOT_READY, 1'b0};
                phase_nxt = PH_IDLE;
              end
            end else begin
              case (phase_r)
                PH_RD_READY: begin
                  phase_nxt = PH_RD_FRAME;
                  ek_nxt    = KIND_FRAME;
                end
                PH_WR_XFER_POLL: begin
                  phase_nxt = PH_WR_PROG;
                  ek_nxt    = KIND_FRAME;
                end
                PH_WR_PROG_POLL: begin
                  phase_nxt = PH_WR_CMP;
                  ek_nxt    = KIND_FRAME;
                end
                default: begin
                  cmd.poll_fresh = 1'b1;
                  phase_nxt      = PH_WR_CHECK;
                  ek_nxt         = KIND_POLL;
                end
              endcase
            end
          end
        end
      end

      SQ_DIV: begin
        if (stat.div_done) begin
          cmd.start_req = 1'b1;
          state_nxt     = SQ_START;
        end
      end

      // first chunk: writes open with a frame, reads wait for ready first
      SQ_START: begin
        state_nxt = SQ_EMIT;
        if (stat.is_write) begin
          phase_nxt = stat.chunk_full ? PH_WR_PROG : PH_WR_XFER;
          ek_nxt    = KIND_FRAME;
        end else begin
          cmd.poll_fresh = 1'b1;
          phase_nxt      = PH_RD_READY;
          ek_nxt         = KIND_POLL;
        end
      end

      SQ_ADV1: begin
        cmd.adv_sum = 1'b1;
        state_nxt   = SQ_ADV2;
      end

      SQ_ADV2: begin
        if (stat.all_done) begin
          {ek_nxt, rc_nxt, dz_nxt} = {KIND_DONE, RES_OK, 1'b0};
          phase_nxt = PH_IDLE;
          state_nxt = SQ_EMIT;
        end else begin
          cmd.adv_chunk = 1'b1;
          state_nxt     = SQ_ADV3;
        end
      end

      SQ_ADV3: begin
        state_nxt = SQ_EMIT;
        ek_nxt    = KIND_FRAME;
        if (stat.is_write) begin
          phase_nxt = stat.chunk_full ? PH_WR_PROG : PH_WR_XFER;
        end else begin
          phase_nxt = PH_RD_FRAME;
        end
      end

      SQ_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = SQ_IDLE;
        end
      end

      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      phase_r <= PH_IDLE;
      ek_r    <= KIND_DONE;
      rc_r    <= RES_OK;
      dz_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ek_r    <= ek_nxt;
      rc_r    <= rc_nxt;
      dz_r    <= dz_nxt;
    end
  end

  assign in_stall = (state_r != SQ_IDLE);

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_DIV) |-> (phase_r == PH_IDLE))
    else $error("address split running outside an idle phase");

  a_adv_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_ADV1) |-> (phase_r == PH_RD_FRAME || phase_r == PH_WR_CHECK))
    else $error("chunk advance from wrong phase");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_EMIT && !stat.out_free) |=> (state_r == SQ_EMIT))
    else $error("pending result dropped");

endmodule

### rtl/dataflash_page_access_sequencer.sv
// Page access sequencer for a serial page-organised data flash. One input beat is taken
// at a time. A read or write start runs 24 steps of a bit-serial divider that splits the
// byte address into page and offset; its first result is then loaded, and the next beat
// can be taken once it is. Zero-length and out-of-range starts skip the divider and go
// straight to a done result. Status replies and frame-finished beats that the phase
// expects load their result directly, unless they complete a chunk: then the bytes done
// are summed first and the request either ends there or moves on to the next chunk.
// The output register lets the next beat be taken while a result still waits.
// Configuration may only be written while no request is running.
// depends on dfps_pkg, dfps_ctrl, dfps_dp
module dataflash_page_access_sequencer #(
  parameter int RETRY_LIMIT    = 50,
  parameter int MAX_PAGE_BYTES = 1024,
  parameter int ADDRESS_BITS   = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dfps_pkg::dfps_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dfps_pkg::dfps_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [dfps_pkg::LEN_W-1:0] cfg_wdata
);
  import dfps_pkg::*;

  dfps_cmd_t  cmd;
  dfps_stat_t stat;

  dfps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dfps_dp #(
    .RETRY_LIMIT    (RETRY_LIMIT),
    .MAX_PAGE_BYTES (MAX_PAGE_BYTES),
    .ADDRESS_BITS   (ADDRESS_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### verif/dataflash_page_access_sequencer_tb.sv
// self-checking testbench for dataflash_page_access_sequencer: plays the flash side,
// answering polls and frames, and checks every result beat against its own predictor
// depends on dfps_pkg and the rtl of the block
module dataflash_page_access_sequencer_tb;
  import dfps_pkg::*;

  localparam int RETRY_LIMIT    = 50;
  localparam int MAX_PAGE_BYTES = 1024;
  localparam int ADDRESS_BITS   = 24;
  localparam int SETTLE_CYCLES  = 40;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RANDOM_BEATS   = 200;
  localparam longint NEVER_HANG = 64'd1 << 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  dfps_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  dfps_out_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_BYTES_PER_PAGE;
  logic [LEN_W-1:0] cfg_wdata = '0;

  // predicted state of the sequencer and its registers
  logic [3:0]        seq_phase = PH_IDLE;
  logic              seq_write = 1'b0;
  logic [PNUM_W-1:0] seq_page = '0;
  logic [PAGE_W-1:0] seq_offset = '0;
  logic [LEN_W-1:0]  seq_total = '0;
  logic [LEN_W-1:0]  seq_finished = '0;
  logic [PAGE_W-1:0] seq_chunk = '0;
  logic [POLL_W-1:0] seq_polls = '0;
  logic [PAGE_W-1:0] reg_page_bytes = RST_BYTES_PER_PAGE;
  logic [3:0]        reg_shift = RST_PAGE_SHIFT;
  logic [LEN_W-1:0]  reg_device_bytes = RST_DEVICE_BYTES;
  logic              reg_wp = 1'b0;

  dfps_out_t due_results [$];
  int error_count = 0;
  int results_checked = 0;
  int useful_beats = 0;
  int stray_beats = 0;
  int settings_used = 1;
  int cycle_count = 0;
  int outcome_count [4] = '{0, 0, 0, 0};
  int hold_left = 0;
  int free_left = 0;
  bit stall_enable = 1'b1;
  bit sender_burst = 1'b0;
  bit pause_pending = 1'b0;

  dataflash_page_access_sequencer #(
    .RETRY_LIMIT(RETRY_LIMIT),
    .MAX_PAGE_BYTES(MAX_PAGE_BYTES),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned usable_page();
    if (reg_page_bytes == 0) return 1;
    if (reg_page_bytes > MAX_PAGE_BYTES) return MAX_PAGE_BYTES;
    return reg_page_bytes;
  endfunction

  function automatic logic [23:0] flash_addr(input bit with_offset);
    logic [47:0] a;
    a = 48'(seq_page) << reg_shift;
    if (with_offset) a = a + 48'(seq_offset);
    return a[23:0];
  endfunction

  function automatic dfps_out_t result_beat(input logic [1:0] kind, input logic [7:0] cmd,
                                            input logic [23:0] addr,
                                            input logic [PAGE_W-1:0] nbytes, input logic rd,
                                            input logic [LEN_W-1:0] done,
                                            input logic [1:0] res);
    dfps_out_t r;
    r.kind = kind;
    r.command_code = cmd;
    r.flash_address = addr;
    r.payload_bytes = nbytes;
    r.payload_is_read = rd;
    r.bytes_done = done;
    r.result_code = res;
    r.write_protect_high = (kind != KIND_DONE) && seq_write && reg_wp;
    return r;
  endfunction

  function automatic dfps_out_t end_request(input logic [LEN_W-1:0] done,
                                            input logic [1:0] res);
    seq_phase = PH_IDLE;
    outcome_count[res]++;
    return result_beat(KIND_DONE, CMD_NONE, '0, '0, 1'b0, done, res);
  endfunction

  function automatic dfps_out_t status_poll(input logic [3:0] next, input bit fresh);
    seq_phase = next;
    if (fresh) seq_polls = 1;
    return result_beat(KIND_POLL, CMD_STATUS, '0, 11'd1, 1'b1, '0, RES_OK);
  endfunction

  function automatic dfps_out_t command_frame(input logic [3:0] next);
    seq_phase = next;
    case (next)
      PH_RD_FRAME: return result_beat(KIND_FRAME, CMD_READ_CONT, flash_addr(1'b1), seq_chunk,
                                      1'b1, '0, RES_OK);
      PH_WR_XFER: return result_beat(KIND_FRAME, CMD_XFER_BUF1, flash_addr(1'b0), '0,
                                     1'b0, '0, RES_OK);
      PH_WR_PROG: return result_beat(KIND_FRAME, CMD_PROG_BUF1, flash_addr(1'b1), seq_chunk,
                                     1'b0, '0, RES_OK);
      default: return result_beat(KIND_FRAME, CMD_CMP_BUF1, flash_addr(1'b0), '0,
                                  1'b0, '0, RES_OK);
    endcase
  endfunction

  // a full page goes straight to program, anything less is merged through buffer 1
  function automatic dfps_out_t begin_write_chunk();
    return command_frame((seq_chunk != usable_page()) ? PH_WR_XFER : PH_WR_PROG);
  endfunction

  function automatic dfps_out_t next_chunk();
    int unsigned p;
    logic [LEN_W-1:0] rem;
    p = usable_page();
    seq_finished = seq_finished + seq_chunk;
    seq_page = seq_page + 1'b1;
    seq_offset = '0;
    if (seq_finished >= seq_total) return end_request(seq_finished, RES_OK);
    rem = seq_total - seq_finished;
    seq_chunk = (rem > p) ? PAGE_W'(p) : PAGE_W'(rem);
    return seq_write ? begin_write_chunk() : command_frame(PH_RD_FRAME);
  endfunction

  function automatic bit predict_beat(input dfps_in_t b, output dfps_out_t r);
    int unsigned p, room;
    r = '0;
    if (seq_phase == PH_IDLE) begin
      if (b.opcode == OP_STATUS || b.opcode == OP_FINISHED) return 1'b0;
      seq_write = (b.opcode == OP_WRITE);
      if (b.transfer_length == 0) begin
        r = end_request('0, RES_OK);
        return 1'b1;
      end
      if (longint'(b.start_address) + longint'(b.transfer_length) >
          longint'(reg_device_bytes)) begin
        r = end_request('0, RES_RANGE);
        return 1'b1;
      end
      p = usable_page();
      seq_total = b.transfer_length;
      seq_finished = '0;
      seq_page = PNUM_W'(b.start_address / p);
      seq_offset = PAGE_W'(b.start_address % p);
      room = p - seq_offset;
      seq_chunk = (b.transfer_length > room) ? PAGE_W'(room) : PAGE_W'(b.transfer_length);
      r = seq_write ? begin_write_chunk() : status_poll(PH_RD_READY, 1'b1);
      return 1'b1;
    end
    if (b.opcode == OP_FINISHED) begin
      case (seq_phase)
        PH_RD_FRAME: r = next_chunk();
        PH_WR_XFER: r = status_poll(PH_WR_XFER_POLL, 1'b1);
        PH_WR_PROG: r = status_poll(PH_WR_PROG_POLL, 1'b1);
        PH_WR_CMP: r = status_poll(PH_WR_CMP_POLL, 1'b1);
        default: return 1'b0;
      endcase
      return 1'b1;
    end
    if (b.opcode != OP_STATUS) return 1'b0;
    if (seq_phase == PH_WR_CHECK) begin
      r = b.status_byte[6] ? end_request(seq_finished, RES_MISMATCH) : next_chunk();
      return 1'b1;
    end
    if (seq_phase != PH_RD_READY && seq_phase != PH_WR_XFER_POLL &&
        seq_phase != PH_WR_PROG_POLL && seq_phase != PH_WR_CMP_POLL) return 1'b0;
    if (!b.status_byte[7]) begin
      if (seq_polls < RETRY_LIMIT) begin
        seq_polls = seq_polls + 1'b1;
        r = status_poll(seq_phase, 1'b0);
      end else begin
        r = end_request(seq_finished, RES_NOT_READY);
      end
      return 1'b1;
    end
    case (seq_phase)
      PH_RD_READY: r = command_frame(PH_RD_FRAME);
      PH_WR_XFER_POLL: r = command_frame(PH_WR_PROG);
      PH_WR_PROG_POLL: r = command_frame(PH_WR_CMP);
      default: r = status_poll(PH_WR_CHECK, 1'b1);
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic dfps_in_t noise_fields();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return dfps_in_t'(raw[$bits(dfps_in_t)-1:0]);
  endfunction

  function automatic bit frame_out();
    return seq_phase == PH_RD_FRAME || seq_phase == PH_WR_XFER ||
           seq_phase == PH_WR_PROG || seq_phase == PH_WR_CMP;
  endfunction

  // what the flash would send back next
  function automatic dfps_in_t reply_beat(input int unsigned ready_pct,
                                          input int unsigned mismatch_pct,
                                          input longint hang_after);
    dfps_in_t b;
    b = noise_fields();
    if (frame_out()) begin
      b.opcode = OP_FINISHED;
    end else begin
      b.opcode = OP_STATUS;
      b.status_byte[7] = (longint'(seq_finished) < hang_after) &&
                         ($urandom_range(0, 99) < ready_pct);
      if (seq_phase == PH_WR_CHECK) b.status_byte[6] = $urandom_range(0, 99) < mismatch_pct;
    end
    return b;
  endfunction

  // a beat the busy block has to ignore
  function automatic dfps_in_t stray_beat();
    dfps_in_t b;
    b = noise_fields();
    case ($urandom_range(0, 2))
      0: b.opcode = frame_out() ? OP_STATUS : OP_FINISHED;
      1: b.opcode = OP_READ;
      default: b.opcode = OP_WRITE;
    endcase
    return b;
  endfunction

  task automatic send_beat(input dfps_in_t b);
    dfps_out_t r;
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_beat(b, r)) due_results.push_back(r);
  endtask

  task automatic idle_gap();
    int unsigned n;
    n = pick_gap();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // beats that produce nothing may still be in flight once the queue is empty
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [LEN_W-1:0] value);
    cfg_index <= index;
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    case (index)
      CFG_BYTES_PER_PAGE: reg_page_bytes = value[PAGE_W-1:0];
      CFG_PAGE_SHIFT: reg_shift = value[3:0];
      CFG_DEVICE_BYTES: reg_device_bytes = value;
      default: reg_wp = value[0];
    endcase
  endtask

  task automatic program_regs(input logic [PAGE_W-1:0] page_bytes, input logic [3:0] shift,
                              input logic [LEN_W-1:0] dev_bytes, input logic wp);
    write_reg(CFG_BYTES_PER_PAGE, LEN_W'(page_bytes));
    write_reg(CFG_PAGE_SHIFT, LEN_W'(shift));
    write_reg(CFG_DEVICE_BYTES, dev_bytes);
    write_reg(CFG_WP_PRESENT, LEN_W'(wp));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // one request from start to done, with the flash side answering each poll and frame
  task automatic run_request(input logic [1:0] op, input logic [23:0] addr,
                             input logic [LEN_W-1:0] len, input int unsigned ready_pct,
                             input int unsigned mismatch_pct, input int unsigned noise_pct,
                             input longint hang_after);
    dfps_in_t b;
    b = noise_fields();
    b.opcode = op;
    b.start_address = addr;
    b.transfer_length = len;
    send_beat(b);
    useful_beats++;
    while (seq_phase != PH_IDLE) begin
      if (pause_pending) begin
        wait_drained();
        pause_pending = 1'b0;
      end else if (!sender_burst) begin
        idle_gap();
      end
      if ($urandom_range(0, 99) < noise_pct) begin
        send_beat(stray_beat());
        stray_beats++;
      end else begin
        send_beat(reply_beat(ready_pct, mismatch_pct, hang_after));
        useful_beats++;
      end
    end
    if (!sender_burst) idle_gap();
  endtask

  task automatic random_request();
    int unsigned p, len, addr, lim, roll;
    longint need, hang;
    logic [1:0] op;
    p = usable_page();
    op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    roll = $urandom_range(0, 99);
    if (roll < 92) begin
      if (roll < 4) len = 0;
      else if (roll < 60) len = $urandom_range(1, p);
      else len = $urandom_range(p + 1, 4 * p);
      lim = (reg_device_bytes >= len) ? reg_device_bytes - len : 0;
      if (lim > 24'hFFFFFF) lim = 24'hFFFFFF;
      addr = $urandom_range(0, lim);
      if ($urandom_range(0, 3) == 0) addr = addr - addr % p;
    end else begin
      // just past the end of the device
      addr = $urandom_range(0, 24'hFFFFFF);
      need = longint'(reg_device_bytes) - addr + 1;
      if (need < 1) need = 1;
      if (need > 16777216) len = 0;
      else len = int'(need) + $urandom_range(0, 64);
      if (len > 16777216) len = 16777216;
    end
    hang = ($urandom_range(0, 24) == 0) ? longint'($urandom_range(0, len)) : NEVER_HANG;
    run_request(op, 24'(addr), LEN_W'(len), $urandom_range(60, 100), 8, 6, hang);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    run_request(OP_READ, 24'd0, 25'd1, 100, 0, 0, NEVER_HANG);
    run_request(OP_WRITE, 24'h07FFFF, 25'd2, 100, 0, 0, NEVER_HANG);
    run_request(OP_READ, 24'h07FFFF, 25'd1, 100, 0, 0, NEVER_HANG);
  endtask

  task automatic test_special_cases();
    dfps_in_t b;
    settle();
    program_regs(11'd1024, 4'd11, 25'd16777216, 1'b1);
    // last byte of the largest device, device address wraps
    run_request(OP_READ, 24'hFFFFFF, 25'd1, 100, 0, 0, NEVER_HANG);
    run_request(OP_WRITE, 24'h000400, 25'd0, 100, 0, 0, NEVER_HANG);
    run_request(OP_READ, 24'd1, 25'd16777216, 100, 0, 0, NEVER_HANG);
    run_request(OP_WRITE, 24'd0, 25'd1024, 100, 0, 0, NEVER_HANG);
    // straddles a page, compare fails on the first chunk
    run_request(OP_WRITE, 24'h0003FF, 25'd2, 100, 100, 0, NEVER_HANG);
    // status reply and frame finished with nothing running
    b = noise_fields();
    b.opcode = OP_STATUS;
    b.status_byte = 8'hFF;
    send_beat(b);
    b.opcode = OP_FINISHED;
    b.status_byte = 8'h00;
    send_beat(b);
    stray_beats += 2;
  endtask

  task automatic test_retry_limit();
    settle();
    program_regs(11'd256, 4'd9, 25'd524288, 1'b1);
    run_request(OP_READ, 24'd100, 25'd10, 100, 0, 0, 0);
    // first chunk completes, then the device hangs on the second
    run_request(OP_WRITE, 24'd300, 25'd600, 100, 0, 0, 1);
  endtask

  task automatic test_odd_pages();
    settle();
    program_regs(11'd0, 4'd15, 25'h1FFFFFF, 1'b0);
    repeat (5) random_request();
    settle();
    program_regs(11'd2047, 4'd0, 25'd0, 1'b1);
    repeat (3) random_request();
    settle();
    program_regs(11'd2047, 4'd0, 25'd16777216, 1'b0);
    repeat (5) random_request();
  endtask

  task automatic test_random_traffic();
    int first;
    logic [PAGE_W-1:0] page_bytes;
    logic [LEN_W-1:0] dev_bytes;
    first = useful_beats;
    while (useful_beats - first < RANDOM_BEATS) begin
      settle();
      case ($urandom_range(0, 5))
        0: page_bytes = 11'd1;
        1: page_bytes = PAGE_W'($urandom_range(2, 16));
        2: page_bytes = 11'd256;
        3: page_bytes = PAGE_W'($urandom_range(17, 1024));
        4: page_bytes = 11'd1024;
        default: page_bytes = $urandom_range(0, 1) ? 11'd0 : PAGE_W'($urandom_range(1025, 2047));
      endcase
      case ($urandom_range(0, 4))
        0: dev_bytes = LEN_W'($urandom_range(0, 4096));
        1: dev_bytes = 25'd16777216;
        2: dev_bytes = 25'h1FFFFFF;
        default: dev_bytes = LEN_W'($urandom_range(4097, 33554431));
      endcase
      program_regs(page_bytes, 4'($urandom_range(0, 15)), dev_bytes, 1'($urandom_range(0, 1)));
      sender_burst = ($urandom_range(0, 3) == 0);
      stall_enable = ($urandom_range(0, 3) != 0);
      pause_pending = 1'b1;
      repeat ($urandom_range(6, 14)) random_request();
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_result(input string what, input dfps_out_t want, input dfps_out_t seen);
    error_count++;
    if (error_count <= 10) begin
      $display("%s: want kind %0d cmd %02h addr %06h bytes %0d rd %0b done %0d res %0d wp %0b",
               what, want.kind, want.command_code, want.flash_address, want.payload_bytes,
               want.payload_is_read, want.bytes_done, want.result_code, want.write_protect_high);
      $display("  got kind %0d cmd %02h addr %06h bytes %0d rd %0b done %0d res %0d wp %0b",
               seen.kind, seen.command_code, seen.flash_address, seen.payload_bytes,
               seen.payload_is_read, seen.bytes_done, seen.result_code, seen.write_protect_high);
    end
  endtask

  always @(posedge clk) begin : result_check
    dfps_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report_result("result beat with nothing due", '0, out_data);
      end else begin
        want = due_results.pop_front();
        results_checked++;
        if (want !== out_data) report_result("wrong result beat", want, out_data);
      end
    end
  end

  // receiver back-pressure: short stalls mostly, the odd long one, calm stretches
  always @(posedge clk) begin
    if (!rst_n || !stall_enable) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left = free_left - 1;
    end else begin
      out_stall <= 1'b0;
      free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 6);
      hold_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results due", cycle_count,
               due_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_special_cases();
    test_retry_limit();
    test_odd_pages();
    test_random_traffic();
    settle();
    $display("requests: %0d ok, %0d out of range, %0d not ready, %0d compare mismatch",
             outcome_count[RES_OK], outcome_count[RES_RANGE], outcome_count[RES_NOT_READY],
             outcome_count[RES_MISMATCH]);
    $display("%0d beats in (%0d ignored ones), %0d results checked, %0d register settings",
             useful_beats + stray_beats, stray_beats, results_checked, settings_used);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### dataflash_page_access_sequencer.f
rtl/dfps_pkg.sv
rtl/dfps_div.sv
rtl/dfps_dp.sv
rtl/dfps_ctrl.sv
rtl/dataflash_page_access_sequencer.sv
verif/dataflash_page_access_sequencer_tb.sv
